FILE: rtl/msig_pkg.sv
// ----------------------------------------------------------------------------
// msig_pkg
// Shared types and constants for the masked byte signature scanner.
// ----------------------------------------------------------------------------
package msig_pkg;

    // Widths fixed by the register map and the stream fields
    localparam int ADDR_W     = 48;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 8;
    localparam int LEN_W      = 5;
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SIG_SLOTS  = 24;
    localparam int OUT_DATA_W = ADDR_W + CNT_W;

    // Default depth of the compare chain
    localparam int MAX_SIG_LEN_DEF = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIG_LOW  = 3'd0,
        CFG_SIG_MID  = 3'd1,
        CFG_SIG_HIGH = 3'd2,
        CFG_WILDCARD = 3'd3,
        CFG_SIG_LEN  = 3'd4,
        CFG_BASE     = 3'd5,
        CFG_CAP      = 3'd6
    } t_cfg_reg;

    // One result transfer
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
        logic              done;
        logic [CNT_W-1:0]  total;
    } t_result;

endpackage

FILE: rtl/msig_cell.sv
// ----------------------------------------------------------------------------
// msig_cell
// One window cell: holds one region byte, hands it to the next cell on each
// transfer and compares the incoming byte against its signature byte.
// ----------------------------------------------------------------------------
module msig_cell (
    input  logic       i_clk,
    input  logic       i_load,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_sig_byte,
    input  logic       i_wild,
    input  logic       i_active,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;

    // Advance the window on each accepted byte
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte;
        end
    end

    // Compare the byte this cell holds after the shift
    assign o_hit  = !i_active || i_wild || (i_byte == i_sig_byte);
    assign o_byte = r_byte;

endmodule

FILE: rtl/msig_skid.sv
// ----------------------------------------------------------------------------
// msig_skid
// Output register with one skid entry for the result stream.
// ----------------------------------------------------------------------------
module msig_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  msig_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output msig_pkg::t_result o_data,
    input  logic              i_ready
);

    import msig_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    push;
    logic    pop;

    assign o_ready = !r_skid_valid;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && i_ready;

    // Control: refill the output from the skid first, then from the input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= i_data;
            end
        end else if (push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: rtl/masked_byte_signature_scanner_core.sv
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner_core
// Streams a memory region one byte per transfer and reports the start
// address of each match of a wildcard-masked byte signature, up to a cap.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while its input is ready: a chain of
// MAX_SIG_LEN window cells shifts the byte in and compares every position
// against its signature byte in parallel, and results are registered. A result
// transfer appears only when a match is reported or the byte carries tlast;
// tlast on the output marks scan_done, and the scan state clears after it.
// Results pass through an output register with one skid entry, so input stays
// ready while a single result waits; a second waiting result stalls the input.
// Signature byte 0 is always compared exactly. Configuration is written
// through the plain write port while no transfer is in flight; the user must
// keep to this, as the block itself does not enforce it.
module masked_byte_signature_scanner_core #(
    parameter int MAX_SIG_LEN = msig_pkg::MAX_SIG_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [msig_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [msig_pkg::WORD_W-1:0]      i_cfg_data,
    // region byte stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // [7:0] data_byte
    input  logic                             i_s_axis_tlast,  // last_byte
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [msig_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // [47:0] match_address,
                                                              // [55:48] match_total
    output logic                             o_m_axis_tuser,  // match_found
    output logic                             o_m_axis_tlast   // scan_done
);

    import msig_pkg::*;

    // Configuration registers
    logic [WORD_W-1:0]    r_sig_low;
    logic [WORD_W-1:0]    r_sig_mid;
    logic [WORD_W-1:0]    r_sig_high;
    logic [SIG_SLOTS-1:0] r_wild;
    logic [LEN_W-1:0]     r_sig_len;
    logic [ADDR_W-1:0]    r_base;
    logic [CNT_W-1:0]     r_cap;

    // Scan state
    logic [ADDR_W-1:0]    r_offset;
    logic [CNT_W-1:0]     r_seen;

    logic                 accept;
    logic                 skid_ready;
    logic [LEN_W-1:0]     len_m1;
    logic [7:0]           chain [MAX_SIG_LEN+1];
    logic [MAX_SIG_LEN-1:0] hits;
    logic                 full_window;
    logic                 found;
    logic [CNT_W-1:0]     n_seen;
    t_result              result;
    t_result              out_result;

    // Pick signature byte idx out of the three signature words
    function automatic logic [7:0] sig_byte(
        input logic [WORD_W-1:0] lo,
        input logic [WORD_W-1:0] mid,
        input logic [WORD_W-1:0] hi,
        input logic [LEN_W-1:0]  idx
    );
        logic [WORD_W-1:0] word;
        case (idx[4:3])
            2'd0:    word = lo;
            2'd1:    word = mid;
            2'd2:    word = hi;
            default: word = '0;
        endcase
        return word[{idx[2:0], 3'b000} +: 8];
    endfunction

    // Hold configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_low  <= '0;
            r_sig_mid  <= '0;
            r_sig_high <= '0;
            r_wild     <= '0;
            r_sig_len  <= LEN_W'(1);
            r_base     <= '0;
            r_cap      <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SIG_LOW:  r_sig_low  <= i_cfg_data;
                CFG_SIG_MID:  r_sig_mid  <= i_cfg_data;
                CFG_SIG_HIGH: r_sig_high <= i_cfg_data;
                CFG_WILDCARD: r_wild     <= i_cfg_data[SIG_SLOTS-1:0];
                CFG_SIG_LEN:  r_sig_len  <= i_cfg_data[LEN_W-1:0];
                CFG_BASE:     r_base     <= i_cfg_data[ADDR_W-1:0];
                CFG_CAP:      r_cap      <= i_cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp the length to 1..MAX_SIG_LEN, kept as length minus one
    always_comb begin
        if (r_sig_len == '0) begin
            len_m1 = '0;
        end else if (r_sig_len > LEN_W'(MAX_SIG_LEN)) begin
            len_m1 = LEN_W'(MAX_SIG_LEN - 1);
        end else begin
            len_m1 = r_sig_len - LEN_W'(1);
        end
    end

    assign o_s_axis_tready = skid_ready;
    assign accept          = i_s_axis_tvalid && skid_ready;
    assign chain[0]        = i_s_axis_tdata;

    // Window cells: cell k compares the byte k places back against
    // signature byte len-1-k
    for (genvar k = 0; k < MAX_SIG_LEN; k++) begin : g_cell
        logic [LEN_W-1:0]     sig_idx;
        logic [SIG_SLOTS-1:0] wild_sh;
        logic                 active;

        assign active  = (LEN_W'(k) <= len_m1);
        assign sig_idx = len_m1 - LEN_W'(k);
        assign wild_sh = r_wild >> sig_idx;

        msig_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (accept),
            .i_byte     (chain[k]),
            .i_sig_byte (sig_byte(r_sig_low, r_sig_mid, r_sig_high, sig_idx)),
            .i_wild     (wild_sh[0] && (sig_idx != '0)),
            .i_active   (active),
            .o_byte     (chain[k+1]),
            .o_hit      (hits[k])
        );
    end

    // Match decision and result
    assign full_window = (r_offset >= ADDR_W'(len_m1));
    assign found       = (&hits) && full_window && (r_seen < r_cap);
    assign n_seen      = found ? (r_seen + CNT_W'(1)) : r_seen;

    always_comb begin
        result.found = found;
        result.addr  = found ? (r_base + r_offset - ADDR_W'(len_m1)) : '0;
        result.done  = i_s_axis_tlast;
        result.total = n_seen;
    end

    // Advance the scan state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_seen   <= '0;
        end else if (accept) begin
            if (i_s_axis_tlast) begin
                r_offset <= '0;
                r_seen   <= '0;
            end else begin
                r_offset <= r_offset + ADDR_W'(1);
                r_seen   <= n_seen;
            end
        end
    end

    // Register results
    msig_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept && (found || i_s_axis_tlast)),
        .i_data  (result),
        .o_ready (skid_ready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_result),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {out_result.total, out_result.addr};
    assign o_m_axis_tuser = out_result.found;
    assign o_m_axis_tlast = out_result.done;

endmodule
